// ----- hdl/adpm_pkg.sv -----
// Shared constants and types for the approximate DNA pattern matcher.
// No dependencies; every module of the block imports this package.
package adpm_pkg;

  localparam int PATTERN_LEN = 32;  // characters per pattern, 2..32
  localparam int MAX_DIST    = 3;   // highest edit distance tracked, 1..7
  localparam int GROUP_SIZE  = 4;   // patterns matched in parallel, 1..4

  localparam int DIST_CNT  = MAX_DIST + 1;
  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = 2;
  localparam int REG_W     = 64;
  localparam int CODE_W    = 2;
  localparam int CLASS_W   = 4;
  localparam int HITS_W    = 4;
  localparam int PAT_BITS  = CODE_W * PATTERN_LEN;

  typedef logic [DIST_CNT-1:0] dist_t;    // one bit per distance
  typedef logic [CLASS_W-1:0]  class_t;   // class bits of one text symbol
  typedef logic [CODE_W-1:0]   code_t;    // class code of one pattern character
  typedef logic [PAT_BITS-1:0] pattern_t; // all codes of one pattern
  typedef logic [REG_W-1:0]    reg_t;
  typedef logic [HITS_W-1:0]   hits_t;

endpackage

// ----- hdl/adpm_cell.sv -----
// One pattern row of the match automaton: holds the row's cells of the
// previous text position. Depends on adpm_pkg.
module adpm_cell
  import adpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,      // a text symbol is taken this cycle
  input  class_t cls_i,
  input  code_t  code_i,
  input  dist_t  up_prev_i,  // previous-position cells of the row above
  input  dist_t  up_cur_i,   // current-position cells of the row above
  output dist_t  prev_o,
  output dist_t  cur_o
);

  dist_t prev_q, prev_d;
  dist_t cur;
  logic  p;

  assign p = cls_i[code_i];

  always_comb begin
    cur[0] = up_prev_i[0] & p;
    for (int j = 1; j < DIST_CNT; j++) begin
      cur[j] = (up_prev_i[j] & p) | (up_prev_i[j-1] & ~p)
             | prev_q[j-1] | up_cur_i[j-1];
    end
  end

  assign prev_d = adv_i ? cur : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

  assign prev_o = prev_q;
  assign cur_o  = cur;

endmodule

// ----- hdl/adpm_lane.sv -----
// One pattern: a chain of row cells plus the last-row hit decode.
// Depends on adpm_pkg and adpm_cell.
module adpm_lane
  import adpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  class_t   cls_i,
  input  pattern_t codes_i,
  output dist_t    hit_o
);

  dist_t prev_w [PATTERN_LEN];
  dist_t cur_w  [PATTERN_LEN];
  dist_t last;

  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_row
    dist_t up_prev, up_cur;
    if (i == 0) begin : g_top
      // top boundary: all-ones above gives p at distance 0 and ones beyond
      assign up_prev = '1;
      assign up_cur  = '0;
    end else begin : g_mid
      assign up_prev = prev_w[i-1];
      assign up_cur  = cur_w[i-1];
    end
    adpm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv_i),
      .cls_i    (cls_i),
      .code_i   (codes_i[CODE_W*i +: CODE_W]),
      .up_prev_i(up_prev),
      .up_cur_i (up_cur),
      .prev_o   (prev_w[i]),
      .cur_o    (cur_w[i])
    );
  end

  assign last = cur_w[PATTERN_LEN-1];

  // exact distance: set at j, clear at j-1
  always_comb begin
    hit_o[0] = last[0];
    for (int j = 1; j < DIST_CNT; j++) begin
      hit_o[j] = last[j] & ~last[j-1];
    end
  end

endmodule

// ----- hdl/approx_dna_pattern_matcher.sv -----
// Top level of the approximate DNA pattern matcher: pattern registers,
// one lane per pattern, and a two-entry output stage. Depends on adpm_pkg, adpm_lane.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------
//   in      | sink      | in_valid_i / in_stall_o | class_bits_i [3:0]
//   out     | source    | out_valid_o/out_stall_i | distance_hits_o [3:0]
//   cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One item per cycle while in_stall_o is low. The whole automaton update for
// a symbol is combinational AND/OR logic through the cell chain (diagonal
// depth MAX_DIST rows); the result is registered at the edge that takes the
// item, in the output register or else the skid entry. Two output entries let
// input continue while one result waits; in_stall_o rises only once both are full.
// Reset clears the cells, the pattern registers and the output stage.
module approx_dna_pattern_matcher
  import adpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  class_t               class_bits_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hits_t                distance_hits_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  reg_t                 cfg_data_i
);

  reg_t  pat_q [NUM_REGS];
  logic  acc;
  dist_t lane_hit [GROUP_SIZE];
  dist_t grp_hit;
  hits_t hits;

  // pattern registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) pat_q[r] <= '0;
    end else if (cfg_we_i) begin
      pat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign acc = in_valid_i & ~in_stall_o;

  for (genvar g = 0; g < GROUP_SIZE; g++) begin : g_lane
    adpm_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (acc),
      .cls_i  (class_bits_i),
      .codes_i(pat_q[g][PAT_BITS-1:0]),
      .hit_o  (lane_hit[g])
    );
  end

  always_comb begin
    grp_hit = '0;
    for (int g = 0; g < GROUP_SIZE; g++) grp_hit = grp_hit | lane_hit[g];
  end

  // distances beyond the result width are dropped; missing ones read zero
  for (genvar k = 0; k < HITS_W; k++) begin : g_hits
    if (k < DIST_CNT) begin : g_used
      assign hits[k] = grp_hit[k];
    end else begin : g_zero
      assign hits[k] = 1'b0;
    end
  end

  // output register plus skid entry
  logic  out_valid_q, out_valid_d;
  logic  skid_valid_q, skid_valid_d;
  hits_t out_data_q, out_data_d;
  hits_t skid_data_q, skid_data_d;
  logic  take;

  assign take = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (acc) begin
        out_valid_d = 1'b1;
        out_data_d  = hits;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (acc) begin
      skid_valid_d = 1'b1;
      skid_data_d  = hits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign distance_hits_o = out_data_q;

endmodule

// ----- sim/adpm_checker.sv -----
// Scoreboard for the approximate DNA pattern matcher: mirrors the pattern
// registers, runs its own copy of the match automaton and checks every result.
// Depends on adpm_pkg.
module adpm_checker
  import adpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  class_t               class_bits_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  hits_t                distance_hits_i,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  reg_t                 cfg_data_i,
  output int                   mismatch_cnt_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  reg_t   pattern_regs [NUM_REGS];
  dist_t  prev_cells [GROUP_SIZE][PATTERN_LEN];  // cells of the previous position
  hits_t  expected_hits_q [$];
  hits_t  want;

  // One text position through every pattern lane; returns the hit vector.
  function automatic hits_t advance_automaton(class_t cls);
    dist_t nxt [PATTERN_LEN];
    hits_t hits;
    code_t code;
    logic  p;
    hits = '0;
    for (int g = 0; g < GROUP_SIZE; g++) begin
      for (int i = 0; i < PATTERN_LEN; i++) begin
        code = pattern_regs[g][CODE_W*i +: CODE_W];
        p    = cls[code];
        if (i == 0) begin
          nxt[0]    = '1;
          nxt[0][0] = p;
        end else begin
          nxt[i][0] = prev_cells[g][i-1][0] & p;
          for (int j = 1; j < DIST_CNT; j++) begin
            nxt[i][j] = (prev_cells[g][i-1][j] & p) | (prev_cells[g][i-1][j-1] & ~p)
                      | prev_cells[g][i][j-1] | nxt[i-1][j-1];
          end
        end
      end
      if (nxt[PATTERN_LEN-1][0]) hits[0] = 1'b1;
      // exact distance only: a hit at j hides all hits above it
      for (int j = 1; j < DIST_CNT; j++) begin
        if (j < HITS_W && nxt[PATTERN_LEN-1][j] && !nxt[PATTERN_LEN-1][j-1])
          hits[j] = 1'b1;
      end
      for (int i = 0; i < PATTERN_LEN; i++) prev_cells[g][i] = nxt[i];
    end
    return hits;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) pattern_regs[r] = '0;
      for (int g = 0; g < GROUP_SIZE; g++) begin
        for (int i = 0; i < PATTERN_LEN; i++) prev_cells[g][i] = '0;
      end
      expected_hits_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_hits_q.size() == 0) begin
          $display("%0t ns: distance_hits %h with no item outstanding",
                   $time, distance_hits_i);
          mismatch_cnt_o++;
        end else begin
          want = expected_hits_q.pop_front();
          if (distance_hits_i !== want) begin
            $display("%0t ns: distance_hits expected %h, got %h",
                     $time, want, distance_hits_i);
            mismatch_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_hits_q.push_back(advance_automaton(class_bits_i));
      if (cfg_we_i && cfg_idx_i < NUM_REGS)
        pattern_regs[cfg_idx_i] = cfg_data_i;
      pending_o = expected_hits_q.size();
    end
  end

endmodule

// ----- sim/approx_dna_pattern_matcher_tb.sv -----
// Testbench top for the approximate DNA pattern matcher: drives text symbols
// and pattern loads, throttles the result side, and reports the verdict.
// Depends on adpm_pkg, approx_dna_pattern_matcher and adpm_checker.
module approx_dna_pattern_matcher_tb
  import adpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;  // far above the slowest legal run
  localparam int LONG_HOLD   = 80;       // result-side hold-off, fills the block
  localparam int TAIL_CYCLES = 4;        // wait after the final drain, before the verdict

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  class_t               class_bits_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  hits_t                distance_hits_o;
  logic                 cfg_we_i     = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i    = '0;
  reg_t                 cfg_data_i   = '0;

  int   mismatch_cnt;
  int   pending;
  int   cycle_cnt = 0;
  int   sent_cnt  = 0;
  bit   send_burst = 1'b0;
  reg_t pat_val [NUM_REGS];             // what the pattern registers hold now
  int   err_pct_tbl [4] = '{0, 3, 8, 20};

  always #2 clk_i = ~clk_i;

  approx_dna_pattern_matcher u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .class_bits_i   (class_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .distance_hits_o(distance_hits_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  adpm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .class_bits_i   (class_bits_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .distance_hits_i(distance_hits_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // Per-item wait on either side; in a burst stretch nobody idles.
  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 14));
  endfunction

  // Text symbol whose class bits do or do not contain class c; the other
  // bits are random now and then, since a symbol may sit in several classes.
  function automatic class_t symbol_for(code_t c, bit present);
    class_t s;
    s    = ($urandom_range(0, 3) == 0) ? class_t'($urandom_range(0, 15)) : '0;
    s[c] = present;
    return s;
  endfunction

  // Offer one item and hold it until the block takes it. valid is only
  // lowered when a gap follows, so back-to-back items never see a
  // low-then-high pair of updates in one time step.
  task automatic send_symbol(input class_t cls);
    int gap;
    if (sent_cnt % 40 == 0) send_burst = ($urandom_range(0, 2) == 0);
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    class_bits_i <= cls;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  // Stop offering and wait until every outstanding result has come back.
  // Pending is sampled at the falling edge, away from the checker's update.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Load all four patterns; only done once the block is empty.
  task automatic load_patterns(input reg_t p0, input reg_t p1, input reg_t p2,
                               input reg_t p3);
    drain();
    pat_val[0] = p0;
    pat_val[1] = p1;
    pat_val[2] = p2;
    pat_val[3] = p3;
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r[REG_IDX_W-1:0];
      cfg_data_i <= pat_val[r];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Walk the text through one pattern, with substitutions, insertions and
  // deletions at the given rate, so the automaton reaches the last row at
  // small distances instead of dying in the first rows on random text.
  task automatic send_pattern_run(input int g, input int err_pct);
    code_t c;
    int    i;
    i = 0;
    while (i < PATTERN_LEN) begin
      c = pat_val[g][CODE_W*i +: CODE_W];
      if ($urandom_range(0, 99) < err_pct) begin
        case ($urandom_range(0, 2))
          0: begin
            send_symbol(symbol_for(c, 1'b0));  // substitution
            i++;
          end
          1: send_symbol(class_t'($urandom_range(0, 15)));  // insertion
          default: i++;  // deletion
        endcase
      end else begin
        send_symbol(symbol_for(c, 1'b1));
        i++;
      end
    end
  endtask

  // Mostly pattern walks with random errors, the rest plain noise.
  task automatic run_phase(input int n_items);
    int stop_at;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(0, 9) < 7)
        send_pattern_run($urandom_range(0, GROUP_SIZE - 1),
                         err_pct_tbl[$urandom_range(0, 3)]);
      else
        repeat ($urandom_range(1, 24)) send_symbol(class_t'($urandom_range(0, 15)));
    end
  endtask

  // Watchdog: a hung handshake or lost result ends up here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: random stall per item, stretches without stalls, and two
  // long hold-offs while the sender keeps offering, so the two-entry output
  // stage fills and in_stall_o must rise.
  initial begin
    int  n;
    int  taken;
    bit  burst;
    taken = 0;
    burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 48 == 0) burst = ($urandom_range(0, 2) == 0);
      n = (taken == 400 || taken == 1300) ? LONG_HOLD : draw_gap(burst);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    for (int r = 0; r < NUM_REGS; r++) pat_val[r] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every class-bit combination under the reset patterns (all
    // code 0), then all classes at once, which every character accepts.
    for (int v = 0; v < 16; v++) send_symbol(class_t'(v));
    repeat (4) send_symbol('1);

    // Reset patterns: a run of class-0 symbols matches exactly.
    run_phase(250);

    // Every character is class 3.
    load_patterns('1, '1, '1, '1);
    run_phase(250);

    // Different pattern per lane, so the OR across lanes matters.
    load_patterns('0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    run_phase(300);

    for (int k = 0; k < 3; k++) begin
      load_patterns({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
      run_phase(280);
    end

    load_patterns('0, '0, '0, '0);
    run_phase(100);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
